FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ECE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ECE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

// Consequent holds after a delay of dly from the antecedent.
`define ECE_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(dly) (cons)) \
	else $error(msg);

`endif

FILE: sv/ece_pkg.sv
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Shared types, formats and polynomial coefficients.
// ----------------------------------------------------------------------------
package ece_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FIELD_W   = FRAC_BITS + 2;
	localparam int T_W       = FRAC_BITS + 1;
	localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

	typedef enum logic [2:0] {
		MODE_LINEAR  = 3'd0,
		MODE_IN      = 3'd1,
		MODE_OUT     = 3'd2,
		MODE_INOUT   = 3'd3,
		MODE_BOUNCE  = 3'd4,
		MODE_ELASTIC = 3'd5
	} mode_t;

	localparam int Q_W = 19;

	typedef struct packed {
		logic [T_W-1:0] t;
		mode_t          mode;
		logic [Q_W-1:0] q;
	} que_entry_t;

	localparam logic [19:0] A_OFF  = 20'd147456;
	localparam logic [19:0] DIV3_M = 20'd699051;
	localparam logic [13:0] RFRAC1 = 14'd5461;
	localparam logic [13:0] RFRAC2 = 14'd10922;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam int BACK_STAGES = 10;

	localparam logic [30:0] IONE = 31'h4000_0000;
	localparam logic [30:0] EXP_C0 = 31'd16377;
	localparam logic [30:0] EXP_C [0:6] = '{
		31'd165394, 31'd1431680, 31'd10327387, 31'd59597083,
		31'd257941248, 31'd744261118, 31'h4000_0000
	};
	localparam logic [30:0] SIN_C0 = 31'd172271;
	localparam logic [30:0] SIN_C [0:3] = '{
		31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
	};

endpackage

FILE: sv/ece_front.sv
// ----------------------------------------------------------------------------
// Easing front end
// Clamps the progress, takes the request and precomputes the elastic phase
// quotient by three.
// ----------------------------------------------------------------------------
module ece_front (
	input  logic                       start,
	input  logic signed [17:0]         progress_in,
	input  logic [2:0]                 ease_mode,
	input  logic                       full,
	output logic                       push,
	output ece_pkg::que_entry_t        ent
);

	logic [ece_pkg::T_W-1:0] t;
	logic [19:0]             a;
	logic [39:0]             prod;

	always_comb begin
		if (progress_in[17]) begin
			t = '0;
		end else if (progress_in[16:0] > ece_pkg::ONE) begin
			t = ece_pkg::ONE;
		end else begin
			t = progress_in[16:0];
		end
		a = 20'(t) * 20'd10 + ece_pkg::A_OFF;
		prod = 40'(a) * 40'(ece_pkg::DIV3_M);
		ent.t = t;
		ent.mode = ece_pkg::mode_t'(ease_mode);
		ent.q = prod[39:21];
	end

	assign push = start && !full;

endmodule

FILE: sv/ece_queue.sv
// ----------------------------------------------------------------------------
// Easing request queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ece_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ece_pkg::que_entry_t   wr_ent,
	input  logic                  pop,
	output ece_pkg::que_entry_t   rd_ent,
	output logic                  full,
	output logic                  empty
);

	ece_pkg::que_entry_t              mem_q [0:ece_pkg::QDEPTH-1];
	logic [ece_pkg::QPTR_W-1:0]       wr_q;
	logic [ece_pkg::QPTR_W-1:0]       rd_q;
	logic [ece_pkg::QCNT_W-1:0]       cnt_q;

	assign full   = (cnt_q == ece_pkg::QCNT_W'(ece_pkg::QDEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_ent = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ECE_ASSERT_NOW(a_no_overflow, push, !full, "push into a full queue")
	`ECE_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from an empty queue")
	`ECE_ASSERT_NEXT(a_cnt_drop, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "count did not drop")

endmodule

FILE: sv/ece_back.sv
// ----------------------------------------------------------------------------
// Easing back end
// Pipelined evaluation of the linear, quadratic, bounce and elastic curves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ece_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  ece_pkg::que_entry_t      in_ent,
	output logic                     pop,
	output logic                     done,
	output logic signed [17:0]       eased_value
);

	typedef enum logic [1:0] {SH15, SH16, SH20, SH22} sh_t;

	typedef struct packed {
		logic [18:0]             op;
		sh_t                     sh;
		logic [ece_pkg::T_W-1:0] base;
		logic                    neg;
	} sq_cmd_t;

	localparam logic [19:0] B4  = 20'd262144;
	localparam logic [19:0] B6  = 20'd393216;
	localparam logic [19:0] B8  = 20'd524288;
	localparam logic [19:0] B9  = 20'd589824;
	localparam logic [19:0] B10 = 20'd655360;
	localparam logic [20:0] B21 = 21'd1376256;
	localparam logic [16:0] OFF2 = 17'd49152;
	localparam logic [16:0] OFF3 = 17'd61440;
	localparam logic [16:0] OFF4 = 17'd64512;
	localparam logic [16:0] HALF = 17'd32768;
	localparam logic [32:0] FIVE_IONE = 33'h1_4000_0000;
	localparam logic [18:0] FOUR_ONE  = 19'd262144;

	// Decode.
	logic [ece_pkg::T_W-1:0] t, u;
	logic [19:0]             t11, x10, a, w;
	logic [20:0]             t22, w21;
	logic [19:0]             rem;
	logic [13:0]             rfrac;
	logic [29:0]             ph, z;
	sq_cmd_t                 cmd_d;
	logic                    el_d;

	always_comb begin
		t   = in_ent.t;
		u   = ece_pkg::ONE - t;
		t11 = 20'(t) * 20'd11;
		x10 = 20'(t) * 20'd10;
		a   = x10 + ece_pkg::A_OFF;
		rem = a - 20'(in_ent.q) * 20'd3;
		case (rem[1:0])
			2'd1: begin
				rfrac = ece_pkg::RFRAC1;
			end
			2'd2: begin
				rfrac = ece_pkg::RFRAC2;
			end
			default: begin
				rfrac = '0;
			end
		endcase
		ph  = {in_ent.q[15:0], rfrac};
		z   = {ph[27:0], 2'b00};
		t22 = {t11, 1'b0};
		w   = '0;
		w21 = '0;
		el_d = (in_ent.mode == ece_pkg::MODE_ELASTIC) && (t != '0) && (t != ece_pkg::ONE);
		cmd_d.op   = '0;
		cmd_d.sh   = SH16;
		cmd_d.base = t;
		cmd_d.neg  = 1'b0;
		case (in_ent.mode)
			ece_pkg::MODE_IN: begin
				cmd_d.op   = 19'(t);
				cmd_d.base = '0;
			end
			ece_pkg::MODE_OUT: begin
				cmd_d.op   = 19'(u);
				cmd_d.base = ece_pkg::ONE;
				cmd_d.neg  = 1'b1;
			end
			ece_pkg::MODE_INOUT: begin
				cmd_d.sh = SH15;
				if (t < HALF) begin
					cmd_d.op   = 19'(t);
					cmd_d.base = '0;
				end else begin
					cmd_d.op   = 19'(u);
					cmd_d.base = ece_pkg::ONE;
					cmd_d.neg  = 1'b1;
				end
			end
			ece_pkg::MODE_BOUNCE: begin
				cmd_d.sh = SH20;
				if (t11 < B4) begin
					cmd_d.op   = 19'(t11);
					cmd_d.base = '0;
				end else if (t11 < B8) begin
					w = (t11 > B6) ? t11 - B6 : B6 - t11;
					cmd_d.op   = 19'(w);
					cmd_d.base = OFF2;
				end else if (t11 < B10) begin
					w = (t11 > B9) ? t11 - B9 : B9 - t11;
					cmd_d.op   = 19'(w);
					cmd_d.base = OFF3;
				end else begin
					w21 = (t22 > B21) ? t22 - B21 : B21 - t22;
					cmd_d.op   = 19'(w21);
					cmd_d.sh   = SH22;
					cmd_d.base = OFF4;
				end
			end
			default: begin
				cmd_d.op = '0;
			end
		endcase
	end

	assign pop = in_vld;

	logic [ece_pkg::BACK_STAGES:1] vld_q;
	logic [ece_pkg::BACK_STAGES:1] el_q;
	logic [9:1]                    qn_q;
	sq_cmd_t                       cmd_s1, cmd_s2;
	logic [37:0]                   sq_s2;
	logic [17:0]                   gen_q [3:9];
	logic [29:0]                   f_q  [1:8];
	logic [3:0]                    k_q  [1:8];
	logic [30:0]                   zs_q [1:8];
	logic [30:0]                   z2_q [1:8];
	logic [30:0]                   ep_q [1:8];
	logic [30:0]                   sp_q [1:8];
	logic [30:0]                   mag_s9;
	logic [17:0]                   eased_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[ece_pkg::BACK_STAGES-1:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= cmd_d;
		el_q[1]  <= el_d;
		qn_q[1]  <= ph[29];
		f_q[1]   <= {x10[15:0], 14'b0};
		k_q[1]   <= x10[19:16];
		zs_q[1]  <= ph[28] ? ece_pkg::IONE - {1'b0, z} : {1'b0, z};
		z2_q[1]  <= '0;
		ep_q[1]  <= ece_pkg::EXP_C0;
		sp_q[1]  <= ece_pkg::SIN_C0;
		for (int i = 2; i <= ece_pkg::BACK_STAGES; i++) begin
			el_q[i] <= el_q[i-1];
		end
		for (int i = 2; i <= 9; i++) begin
			qn_q[i] <= qn_q[i-1];
		end
	end

	// Square and round path for the quadratic and bounce curves.
	logic [38:0] sq_rnd;
	logic [17:0] rnd, gen_d;

	always_comb begin
		case (cmd_s2.sh)
			SH15: begin
				sq_rnd = (39'(sq_s2) + 39'd16384) >> 15;
			end
			SH20: begin
				sq_rnd = (39'(sq_s2) + 39'd524288) >> 20;
			end
			SH22: begin
				sq_rnd = (39'(sq_s2) + 39'd2097152) >> 22;
			end
			default: begin
				sq_rnd = (39'(sq_s2) + 39'd32768) >> 16;
			end
		endcase
		rnd   = sq_rnd[17:0];
		gen_d = cmd_s2.neg ? 18'(cmd_s2.base) - rnd : 18'(cmd_s2.base) + rnd;
	end

	always_ff @(posedge clk) begin
		cmd_s2   <= cmd_s1;
		sq_s2    <= 38'(cmd_s1.op) * 38'(cmd_s1.op);
		gen_q[3] <= gen_d;
		for (int i = 4; i <= 9; i++) begin
			gen_q[i] <= gen_q[i-1];
		end
	end

	// Exponential and sine polynomial stages.
	for (genvar i = 1; i <= 7; i++) begin : g_poly
		logic [60:0] ep_prod;
		logic [61:0] sp_prod;
		logic [30:0] ep_nx, sp_nx, z2_nx;

		always_comb begin
			ep_prod = 61'(ep_q[i]) * 61'(f_q[i]);
			ep_nx   = ece_pkg::EXP_C[i-1] - ep_prod[60:30];
			if (i == 7) begin
				ep_nx = ep_nx >> k_q[i];
			end
			z2_nx = z2_q[i];
			sp_nx = sp_q[i];
			sp_prod = '0;
			if (i == 1) begin
				sp_prod = 62'(zs_q[i]) * 62'(zs_q[i]);
				z2_nx   = sp_prod[60:30];
			end else if (i <= 5) begin
				sp_prod = 62'(sp_q[i]) * 62'(z2_q[i]);
				sp_nx   = ece_pkg::SIN_C[i-2] - sp_prod[60:30];
			end else if (i == 6) begin
				sp_prod = 62'(sp_q[i]) * 62'(zs_q[i]);
				sp_nx   = (sp_prod[61:30] > 32'(ece_pkg::IONE)) ? ece_pkg::IONE
				          : sp_prod[60:30];
			end
		end

		always_ff @(posedge clk) begin
			f_q[i+1]  <= f_q[i];
			k_q[i+1]  <= k_q[i];
			zs_q[i+1] <= zs_q[i];
			z2_q[i+1] <= z2_nx;
			ep_q[i+1] <= ep_nx;
			sp_q[i+1] <= sp_nx;
		end
	end

	// Product and final sum.
	logic [61:0] mag_prod;
	logic [32:0] v;
	logic [18:0] v_rnd;
	logic [17:0] el_val;

	always_comb begin
		mag_prod = 62'(ep_q[8]) * 62'(sp_q[8]);
		v        = qn_q[9] ? FIVE_IONE - 33'(mag_s9) : FIVE_IONE + 33'(mag_s9);
		v_rnd    = 19'((v + 33'd8192) >> 14);
		el_val   = 18'(v_rnd - FOUR_ONE);
	end

	always_ff @(posedge clk) begin
		mag_s9  <= mag_prod[60:30];
		eased_q <= el_q[9] ? el_val : gen_q[9];
	end

	assign done        = vld_q[ece_pkg::BACK_STAGES];
	assign eased_value = eased_q;

	`ECE_ASSERT_DLY(a_pop_to_done, pop, ece_pkg::BACK_STAGES, done, "result strobe missing")
	`ECE_ASSERT_NOW(a_gen_range, done && !el_q[ece_pkg::BACK_STAGES], !eased_value[17] && (eased_value <= 18'(ece_pkg::ONE)), "non-elastic result out of 0..1")
	`ECE_ASSERT_NOW(a_exp_range, vld_q[8] && el_q[8], ep_q[8] <= ece_pkg::IONE, "decay term above one")

endmodule

FILE: sv/easing_curve_evaluator.sv
// ----------------------------------------------------------------------------
// Easing curve evaluator
// Eases a clamped progress value with a linear, quadratic, bounce or elastic curve.
//
// Channel   Direction  Ports                               Handshake
// request   in         progress_in, ease_mode              start && !busy
// result    out        eased_value                         done, one cycle
//
// A request is taken every cycle while busy is low.
// Each taken request passes through the queue, then the back-end pipeline.
// The back-end depth is set by the pipeline of the elastic curve.
// Reset clears the queue and every stage valid flag.
// The receiver cannot stall and the back end takes one request per cycle, so
// the queue never fills and busy stays low.
// ----------------------------------------------------------------------------
module easing_curve_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [17:0] progress_in,
	input  logic [2:0]         ease_mode,
	output logic               done,
	output logic signed [17:0] eased_value
);

	ece_pkg::que_entry_t wr_ent, rd_ent;
	logic                push, pop, full, empty;

	ece_front u_front (
		.start       (start),
		.progress_in (progress_in),
		.ease_mode   (ease_mode),
		.full        (full),
		.push        (push),
		.ent         (wr_ent)
	);

	ece_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_ent (wr_ent),
		.pop    (pop),
		.rd_ent (rd_ent),
		.full   (full),
		.empty  (empty)
	);

	ece_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (!empty),
		.in_ent      (rd_ent),
		.pop         (pop),
		.done        (done),
		.eased_value (eased_value)
	);

	assign busy = full;

endmodule
